### rtl/jse_pkg.sv
// shared types, character codes and limits for the json string escaper
package jse_pkg;

  // one scan slot: a byte to escape or a replacement character
  typedef struct packed {
    logic       vld;
    logic       repl;
    logic [7:0] chr;
  } tok_t;

  localparam int NUM_TOK = 4;

  // one queue entry: everything a single input beat expands to
  typedef struct packed {
    logic                     open_q;
    logic                     close_q;
    logic                     lossy;
    tok_t [NUM_TOK-1:0]       tok;
  } entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam int QUEUE_DEPTH = 4;

  // output phases of one entry: open quote, four slots, close quote
  localparam logic [2:0] PH_OPEN  = 3'd0;
  localparam logic [2:0] PH_CLOSE = 3'd5;
  localparam int         NUM_PH   = 6;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;
  localparam logic [7:0] CH_LC_U   = 8'h75;
  localparam logic [7:0] CH_LC_D   = 8'h64;
  localparam logic [7:0] CH_ZERO   = 8'h30;

  localparam logic [20:0] CP_MIN2    = 21'h00080;
  localparam logic [20:0] CP_MIN3    = 21'h00800;
  localparam logic [20:0] CP_MIN4    = 21'h10000;
  localparam logic [20:0] CP_SUR_LO  = 21'h0D800;
  localparam logic [20:0] CP_SUR_HI  = 21'h0DFFF;
  localparam logic [20:0] CP_MAX     = 21'h10FFFF;

endpackage

### rtl/jse_front.sv
// front end: utf-8 scan of held bytes plus the new byte, classifies each slot
module jse_front
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] in_byte,
  input  logic       in_first,
  input  logic       in_last,
  input  logic       in_nobyte,
  input  logic       accept,
  output entry_t     entry,
  output logic       push,
  output logic [1:0] held_cnt
);

  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];
  logic [1:0] held_cnt_r, held_cnt_nxt;
  logic       seen_r, seen_nxt;

  logic [1:0] hc_eff;
  logic [2:0] cnt;
  logic [7:0] win [7];
  logic       stopped;
  logic [2:0] stop_pos;
  logic [1:0] skip;
  logic       any_repl;
  logic       any_tok;
  logic [2:0] ln;

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    if (c[7:5] == 3'b110) r = 3'd2;
    else if (c[7:4] == 4'b1110) r = 3'd3;
    else if (c[7:3] == 5'b11110) r = 3'd4;
    return r;
  endfunction

  function automatic logic seq_ok(input logic [7:0] b0, input logic [7:0] b1,
                                  input logic [7:0] b2, input logic [7:0] b3,
                                  input logic [2:0] n);
    logic        cont;
    logic [20:0] cp;
    logic [20:0] cp_min;
    cont = (b1[7:6] == 2'b10) &&
           (n < 3'd3 || b2[7:6] == 2'b10) &&
           (n < 3'd4 || b3[7:6] == 2'b10);
    case (n)
      3'd2: begin
        cp     = {10'd0, b0[4:0], b1[5:0]};
        cp_min = CP_MIN2;
      end
      3'd3: begin
        cp     = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
        cp_min = CP_MIN3;
      end
      default: begin
        cp     = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
        cp_min = CP_MIN4;
      end
    endcase
    return cont && cp >= cp_min && !(cp >= CP_SUR_LO && cp <= CP_SUR_HI) &&
           cp <= CP_MAX;
  endfunction

  always_comb begin
    hc_eff = in_first ? 2'd0 : held_cnt_r;
    cnt    = {1'b0, hc_eff} + {2'b00, !in_nobyte};
    for (int k = 0; k < 7; k++) win[k] = 8'h00;
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < hc_eff) win[k] = held_r[k];
    end
    for (int k = 0; k < 4; k++) begin
      if (3'(k) == {1'b0, hc_eff} && !in_nobyte) win[k] = in_byte;
    end

    // walk the window front to back, one slot per byte position
    stopped  = 1'b0;
    stop_pos = cnt;
    skip     = 2'd0;
    any_repl = 1'b0;
    entry    = '0;
    for (int k = 0; k < NUM_TOK; k++) begin
      ln = lead_len(win[k]);
      if (!stopped && 3'(k) < cnt) begin
        if (skip != 2'd0) begin
          entry.tok[k] = '{vld: 1'b1, repl: 1'b0, chr: win[k]};
          skip = skip - 2'd1;
        end else if (!win[k][7]) begin
          entry.tok[k] = '{vld: 1'b1, repl: 1'b0, chr: win[k]};
        end else if (ln == 3'd0) begin
          entry.tok[k] = '{vld: 1'b1, repl: 1'b1, chr: win[k]};
          any_repl = 1'b1;
        end else if ((cnt - 3'(k)) < ln) begin
          // incomplete tail: replace on the last beat, otherwise hold it
          if (in_last) begin
            entry.tok[k] = '{vld: 1'b1, repl: 1'b1, chr: win[k]};
            any_repl = 1'b1;
          end else begin
            stopped  = 1'b1;
            stop_pos = 3'(k);
          end
        end else if (seq_ok(win[k], win[k+1], win[k+2], win[k+3], ln)) begin
          entry.tok[k] = '{vld: 1'b1, repl: 1'b0, chr: win[k]};
          skip = 2'(ln - 3'd1);
        end else begin
          entry.tok[k] = '{vld: 1'b1, repl: 1'b1, chr: win[k]};
          any_repl = 1'b1;
        end
      end
    end

    for (int j = 0; j < 3; j++) held_nxt[j] = win[stop_pos + 3'(j)];
    held_cnt_nxt = (stopped && !in_last) ? 2'(cnt - stop_pos) : 2'd0;
    entry.lossy  = (!in_first && seen_r) || any_repl;
    seen_nxt     = in_last ? 1'b0 : entry.lossy;
    entry.open_q  = in_first;
    entry.close_q = in_last;

    any_tok = 1'b0;
    for (int k = 0; k < NUM_TOK; k++) any_tok = any_tok | entry.tok[k].vld;
    push = accept && (in_first || in_last || any_tok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seen_r     <= 1'b0;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      seen_r     <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int j = 0; j < 3; j++) held_r[j] <= held_nxt[j];
    end
  end

  assign held_cnt = held_cnt_r;

endmodule

### rtl/jse_queue.sv
// short entry queue between the scan front and the byte expander
module jse_queue
  import jse_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  entry_t  wr_entry,
  input  logic    pop,
  output entry_t  rd_entry,
  output q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  always_comb begin
    stat.empty = (cnt_r == CNT_W'(0));
    stat.full  = (cnt_r == CNT_W'(DEPTH));
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    cnt_nxt = cnt_r + CNT_W'(do_push) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr_entry;
  end

  assign rd_entry = mem_r[rd_ptr_r];

endmodule

### rtl/jse_back.sv
// back end: expands queue entries into escaped bytes through an output register
module jse_back
  import jse_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  entry_t     entry,
  input  q_stat_t    stat,
  output logic       pop,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic       out_tuser
);

  logic [2:0]        phase_r, phase_nxt;
  logic [2:0]        sub_r, sub_nxt;
  logic              ovld_r, ovld_nxt;
  logic [7:0]        odata_r;
  logic              olast_r, olossy_r;

  logic [NUM_PH-1:0] present;
  logic [2:0]        cur;
  logic              found;
  logic              has_next;
  tok_t              tk;
  logic [7:0]        ch;
  logic [2:0]        len;
  logic              eos, lossy;
  logic              step, last_sub;
  logic              is_short;
  logic [7:0]        short_ch;

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    return (n < 4'd10) ? (CH_ZERO + {4'd0, n}) : (8'h57 + {4'd0, n});
  endfunction

  always_comb begin
    present[PH_OPEN]  = entry.open_q;
    for (int k = 0; k < NUM_TOK; k++) present[k+1] = entry.tok[k].vld;
    present[PH_CLOSE] = entry.close_q;

    // first live phase at or after the current one
    cur   = PH_OPEN;
    found = 1'b0;
    for (int p = 0; p < NUM_PH; p++) begin
      if (!found && present[p] && 3'(p) >= phase_r) begin
        cur   = 3'(p);
        found = 1'b1;
      end
    end
    has_next = 1'b0;
    for (int p = 0; p < NUM_PH; p++) begin
      if (present[p] && 3'(p) > cur) has_next = 1'b1;
    end

    tk = entry.tok[2'(cur - 3'd1)];
    is_short = 1'b1;
    case (tk.chr)
      CH_QUOTE:  short_ch = CH_QUOTE;
      CH_BSLASH: short_ch = CH_BSLASH;
      CH_LF:     short_ch = CH_LC_N;
      CH_CR:     short_ch = CH_LC_R;
      CH_TAB:    short_ch = CH_LC_T;
      CH_BS:     short_ch = CH_LC_B;
      CH_FF:     short_ch = CH_LC_F;
      default: begin
        short_ch = tk.chr;
        is_short = 1'b0;
      end
    endcase

    eos   = 1'b0;
    lossy = 1'b0;
    if (cur == PH_OPEN) begin
      ch  = CH_QUOTE;
      len = 3'd1;
    end else if (cur == PH_CLOSE) begin
      ch    = CH_QUOTE;
      len   = 3'd1;
      eos   = 1'b1;
      lossy = entry.lossy;
    end else if (tk.repl) begin
      // replacement character
      len = 3'd6;
      case (sub_r)
        3'd0:    ch = CH_BSLASH;
        3'd1:    ch = CH_LC_U;
        3'd2:    ch = CH_LC_F;
        3'd3:    ch = CH_LC_F;
        3'd4:    ch = CH_LC_F;
        default: ch = CH_LC_D;
      endcase
    end else if (is_short) begin
      len = 3'd2;
      ch  = (sub_r == 3'd0) ? CH_BSLASH : short_ch;
    end else if (tk.chr < CH_SPACE) begin
      // other control bytes as a four digit escape
      len = 3'd6;
      case (sub_r)
        3'd0:    ch = CH_BSLASH;
        3'd1:    ch = CH_LC_U;
        3'd2:    ch = CH_ZERO;
        3'd3:    ch = CH_ZERO;
        3'd4:    ch = hex_char(tk.chr[7:4]);
        default: ch = hex_char(tk.chr[3:0]);
      endcase
    end else begin
      len = 3'd1;
      ch  = tk.chr;
    end

    step     = !stat.empty && (!ovld_r || out_tready);
    last_sub = (sub_r == len - 3'd1);
    pop      = step && last_sub && !has_next;

    phase_nxt = phase_r;
    sub_nxt   = sub_r;
    if (step) begin
      if (!last_sub) begin
        sub_nxt = sub_r + 3'd1;
      end else if (has_next) begin
        phase_nxt = cur + 3'd1;
        sub_nxt   = 3'd0;
      end else begin
        phase_nxt = PH_OPEN;
        sub_nxt   = 3'd0;
      end
    end

    ovld_nxt = step || (ovld_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OPEN;
      sub_r   <= 3'd0;
      ovld_r  <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      sub_r   <= sub_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      odata_r  <= ch;
      olast_r  <= eos;
      olossy_r <= lossy;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;
  assign out_tuser  = olossy_r;

endmodule

### rtl/json_string_escaper_utf8_core.sv
// top level of the json string escaper with utf-8 validation
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | in_tvalid/tready   | tdata raw byte, tlast last beat,
//          |     |                    | tuser first beat / no byte
//  out_    | out | out_tvalid/tready  | tdata escaped byte, tlast closing quote,
//          |     |                    | tuser lossy flag
//
// one beat is scanned per cycle while the queue has room, one byte is output per
// cycle while an entry waits and out_tready does not stall it; a beat expands to up to
// 25 bytes, so the expander sets the sustained rate; a beat that only adds to a
// held sequence yields no bytes; a four-entry queue lets the scanner run ahead while
// expansions drain; in_tready drops only when that queue is full, the output register
// holds on out_tready low; beats pass through the queue, then the output register
// reset: synchronous active-low rst_n clears held bytes, lossy flag, queue and output
module json_string_escaper_utf8_core
  import jse_pkg::*;
#(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] data_byte
  input  logic       in_tlast,   // last_item
  input  logic [1:0] in_tuser,   // [0] first_item, [1] no_byte
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic       out_tlast,  // end_of_string
  output logic [0:0] out_tuser   // [0] lossy
);

  entry_t     fe_entry;
  entry_t     q_entry;
  logic       fe_push;
  logic       be_pop;
  logic       accept;
  logic [1:0] held_cnt;
  q_stat_t    q_stat;
  logic       be_lossy;

  // accept whenever the queue has room; empty beats never take a slot
  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && in_tready;

  jse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_byte   (in_tdata),
    .in_first  (in_tuser[0]),
    .in_last   (in_tlast),
    .in_nobyte (in_tuser[1]),
    .accept    (accept),
    .entry     (fe_entry),
    .push      (fe_push),
    .held_cnt  (held_cnt)
  );

  jse_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fe_push),
    .wr_entry (fe_entry),
    .pop      (be_pop),
    .rd_entry (q_entry),
    .stat     (q_stat)
  );

  jse_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .entry      (q_entry),
    .stat       (q_stat),
    .pop        (be_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (be_lossy)
  );

  assign out_tuser[0] = be_lossy;

  // queue status flags never both set
  a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.empty && q_stat.full))
    else $error("queue reports empty and full together");

  // nothing stays held across the end of a string
  a_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_tlast) |=> (held_cnt == 2'd0))
    else $error("held bytes survive a last beat");

  // the end marker only ever sits on the closing quote
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == CH_QUOTE))
    else $error("end of string on a byte other than a quote");

  // lossy is reported on the closing quote only
  a_lossy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[0]) |-> out_tlast)
    else $error("lossy flag outside the closing beat");

endmodule

### dv/escape_scoreboard_pkg.sv
// scoreboard class holding the escaping predictor and the expected output bytes
package escape_scoreboard_pkg;
  import jse_pkg::*;

  typedef struct {
    logic [7:0] chr;
    logic       eos;
    logic       lossy;
  } esc_char_t;

  localparam logic [7:0] ASCII_TOP  = 8'h80;
  localparam logic [7:0] LEAD2_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_TAG  = 8'hC0;
  localparam logic [7:0] LEAD3_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_TAG  = 8'hE0;
  localparam logic [7:0] LEAD4_MASK = 8'hF8;
  localparam logic [7:0] LEAD4_TAG  = 8'hF0;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] CH_LC_A    = 8'h61;

  class escape_scoreboard;
    logic [7:0]  held_q [3];
    int          held_n;
    bit          repl_seen;
    esc_char_t   expected_chars [$];
    int unsigned errors;
    int unsigned checked;

    function new();
      held_n    = 0;
      repl_seen = 0;
      errors    = 0;
      checked   = 0;
      foreach (held_q[i]) held_q[i] = '0;
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction

    function void emit(logic [7:0] chr, logic eos = 1'b0, logic lossy = 1'b0);
      esc_char_t e;
      e.chr   = chr;
      e.eos   = eos;
      e.lossy = lossy;
      expected_chars.push_back(e);
    endfunction

    // replacement character as the six bytes \ufffd
    function void emit_repl();
      emit(CH_BSLASH);
      emit(CH_LC_U);
      emit(CH_LC_F);
      emit(CH_LC_F);
      emit(CH_LC_F);
      emit(CH_LC_D);
      repl_seen = 1;
    endfunction

    function logic [7:0] hex_digit(logic [3:0] n);
      return (n < 4'd10) ? CH_ZERO + {4'd0, n} : CH_LC_A + {4'd0, n} - 8'd10;
    endfunction

    // predicts every output byte that one accepted input beat causes
    function void take_beat(logic [7:0] data, bit first, bit last, bit nob);
      logic [7:0]  win [4];
      logic [7:0]  c;
      logic [20:0] cp;
      int          cnt, pos, len, k;
      bit          ok, stop;
      cnt  = 0;
      pos  = 0;
      stop = 0;
      if (first) begin
        held_n    = 0;
        repl_seen = 0;
        emit(CH_QUOTE);
      end
      for (k = 0; k < held_n; k++) begin
        win[cnt] = held_q[k];
        cnt++;
      end
      if (!nob) begin
        win[cnt] = data;
        cnt++;
      end
      while (pos < cnt && !stop) begin
        c = win[pos];
        if (c < ASCII_TOP) begin
          case (c)
            CH_QUOTE, CH_BSLASH: begin
              emit(CH_BSLASH);
              emit(c);
            end
            CH_LF: begin
              emit(CH_BSLASH);
              emit(CH_LC_N);
            end
            CH_CR: begin
              emit(CH_BSLASH);
              emit(CH_LC_R);
            end
            CH_TAB: begin
              emit(CH_BSLASH);
              emit(CH_LC_T);
            end
            CH_BS: begin
              emit(CH_BSLASH);
              emit(CH_LC_B);
            end
            CH_FF: begin
              emit(CH_BSLASH);
              emit(CH_LC_F);
            end
            default: begin
              if (c < CH_SPACE) begin
                emit(CH_BSLASH);
                emit(CH_LC_U);
                emit(CH_ZERO);
                emit(CH_ZERO);
                emit(hex_digit(c[7:4]));
                emit(hex_digit(c[3:0]));
              end else begin
                emit(c);
              end
            end
          endcase
          pos++;
        end else begin
          if ((c & LEAD2_MASK) == LEAD2_TAG)      len = 2;
          else if ((c & LEAD3_MASK) == LEAD3_TAG) len = 3;
          else if ((c & LEAD4_MASK) == LEAD4_TAG) len = 4;
          else                                    len = 0;
          if (len == 0) begin
            emit_repl();
            pos++;
          end else if (cnt - pos < len) begin
            // short sequence: held back, or replaced on the closing beat
            if (last) begin
              emit_repl();
              pos++;
            end else begin
              stop = 1;
            end
          end else begin
            ok = 1;
            case (len)
              2:       cp = {16'd0, c[4:0]};
              3:       cp = {17'd0, c[3:0]};
              default: cp = {18'd0, c[2:0]};
            endcase
            for (k = 1; k < len; k++) begin
              if ((win[pos+k] & CONT_MASK) != CONT_TAG) ok = 0;
              cp = {cp[14:0], win[pos+k][5:0]};
            end
            if (len == 2 && cp < CP_MIN2) ok = 0;
            if (len == 3 && cp < CP_MIN3) ok = 0;
            if (len == 4 && cp < CP_MIN4) ok = 0;
            if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) ok = 0;
            if (cp > CP_MAX) ok = 0;
            if (ok) begin
              for (k = 0; k < len; k++) emit(win[pos+k]);
              pos += len;
            end else begin
              emit_repl();
              pos++;
            end
          end
        end
      end
      held_n = 0;
      while (pos < cnt && held_n < 3) begin
        held_q[held_n] = win[pos];
        held_n++;
        pos++;
      end
      if (last) begin
        emit(CH_QUOTE, 1'b1, repl_seen);
        repl_seen = 0;
        held_n    = 0;
      end
    endfunction

    // compares one accepted output beat with the oldest expected byte
    function void check_char(logic [7:0] chr, logic eos, logic lossy);
      esc_char_t want;
      if (expected_chars.size() == 0) begin
        $error("output byte 0x%02h arrived with no expected byte pending", chr);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      checked++;
      if (chr !== want.chr) begin
        $error("out_byte: expected 0x%02h, actual 0x%02h", want.chr, chr);
        errors++;
      end
      if (eos !== want.eos) begin
        $error("end_of_string: expected %0b, actual %0b", want.eos, eos);
        errors++;
      end
      if (lossy !== want.lossy) begin
        $error("lossy: expected %0b, actual %0b", want.lossy, lossy);
        errors++;
      end
    endfunction
  endclass

endpackage

### dv/testbench.sv
// top-level testbench of the json string escaper: stimulus, monitors and verdict
module testbench;
  import jse_pkg::*;
  import escape_scoreboard_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any beat on either side before the run is called hung
  localparam int STALL_LIMIT  = 2000;
  // settle time after the last expected byte has come out
  localparam int DRAIN_CYCLES = 10;
  // non-ignored input beats per random phase
  localparam int PHASE_BEATS  = 170;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = '0;   // [7:0] data_byte
  logic       in_tlast   = 1'b0; // last_item
  logic [1:0] in_tuser   = '0;   // [0] first_item, [1] no_byte
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;         // [7:0] out_byte
  logic       out_tlast;         // end_of_string
  logic [0:0] out_tuser;         // [0] lossy

  escape_scoreboard sb;

  int tx_idle_pct = 12;
  int rx_idle_pct = 70;
  int beats_sent   = 0;
  int strings_sent = 0;
  int stall_cycles = 0;

  // bytes of the string being built for the next random string
  logic [7:0] text_q [$];
  // bytes that take a two-character escape
  logic [7:0] esc_pick [7] = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_CR, CH_TAB, CH_BS, CH_FF};

  json_string_escaper_utf8_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #1 clk = ~clk;

  // receiver: random backpressure at the current stall rate
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // monitors on both channels, plus the hang watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready)
        sb.take_beat(in_tdata, in_tuser[0], in_tlast, in_tuser[1]);
      if (out_tvalid && out_tready)
        sb.check_char(out_tdata, out_tlast, out_tuser[0]);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        stall_cycles = 0;
      else
        stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("json_string_escaper_utf8_core verification failed");
        $finish;
      end
    end
  end

  // one input beat; valid stays high into the next beat unless an idle is drawn
  task automatic send_beat(input logic [7:0] b, input bit first, input bit last,
                           input bit nob);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    in_tuser  <= {nob, first};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // a byteless beat with no flags is ignored by the block
    if (!(nob && !first && !last)) beats_sent++;
  endtask

  // utf-8 encoding of cp at a forced length, so overlong and out-of-range forms work
  task automatic encode_cp(input logic [20:0] cp, input int len);
    case (len)
      2: begin
        text_q.push_back({3'b110, cp[10:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      3: begin
        text_q.push_back({4'b1110, cp[15:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
      default: begin
        text_q.push_back({5'b11110, cp[20:18]});
        text_q.push_back({2'b10, cp[17:12]});
        text_q.push_back({2'b10, cp[11:6]});
        text_q.push_back({2'b10, cp[5:0]});
      end
    endcase
  endtask

  // one random string, mostly well-formed utf-8 with escapes mixed in
  task automatic send_string();
    int          ntok, kind, len, idx;
    logic [20:0] cp;
    bit          lead_empty, tail_empty, close;
    text_q.delete();
    ntok = $urandom_range(0, 6);
    repeat (ntok) begin
      kind = $urandom_range(0, 15);
      len  = $urandom_range(2, 4);
      case (kind)
        0, 1, 2, 3: text_q.push_back(8'($urandom_range(8'h20, 8'h7F)));
        4:          text_q.push_back(esc_pick[$urandom_range(0, 6)]);
        5:          text_q.push_back(8'($urandom_range(0, 8'h1F)));
        6, 7, 8, 12, 14: begin
          // well-formed sequence, later broken for bad continuation or truncation
          case (len)
            2: cp = 21'($urandom_range(21'h80, 21'h7FF));
            3: begin
              cp = 21'($urandom_range(21'h800, 21'hFFFF));
              if (cp >= CP_SUR_LO && cp <= CP_SUR_HI) cp = cp ^ 21'h4000;
            end
            default: cp = 21'($urandom_range(21'h10000, 21'h10FFFF));
          endcase
          encode_cp(cp, len);
          if (kind == 12) begin
            idx = text_q.size() - $urandom_range(1, len - 1);
            text_q[idx] = $urandom_range(0, 1) ? 8'($urandom_range(0, 8'h7F))
                                               : 8'($urandom_range(8'hC0, 8'hFF));
          end
          if (kind == 14) begin
            repeat ($urandom_range(1, len - 1)) text_q.delete(text_q.size() - 1);
          end
        end
        9: begin
          // overlong form
          case (len)
            2:       cp = 21'($urandom_range(0, 21'h7F));
            3:       cp = 21'($urandom_range(0, 21'h7FF));
            default: cp = 21'($urandom_range(0, 21'hFFFF));
          endcase
          encode_cp(cp, len);
        end
        10: encode_cp(21'($urandom_range(CP_SUR_LO, CP_SUR_HI)), 3);
        11: encode_cp(21'($urandom_range(21'h110000, 21'h1FFFFF)), 4);
        13: text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                  : 8'($urandom_range(8'hF8, 8'hFF)));
        default: text_q.push_back(8'($urandom_range(0, 255)));
      endcase
    end
    // framing variants: byteless opening or closing beat, abandoned string
    lead_empty = ($urandom_range(0, 5) == 0) || (text_q.size() == 0);
    tail_empty = ($urandom_range(0, 5) == 0);
    close      = ($urandom_range(0, 11) != 0);
    if (lead_empty) send_beat(8'($urandom), 1'b1, close && text_q.size() == 0, 1'b1);
    foreach (text_q[i]) begin
      if ($urandom_range(0, 15) == 0) send_beat(8'($urandom), 1'b0, 1'b0, 1'b1);
      send_beat(text_q[i], i == 0 && !lead_empty,
                close && !tail_empty && i == text_q.size() - 1, 1'b0);
    end
    if (close && tail_empty && text_q.size() != 0)
      send_beat(8'($urandom), 1'b0, 1'b1, 1'b1);
    strings_sent++;
  endtask

  // sender holds off until every expected byte has come out
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int phase;
    int phase_target;
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty string, every escape, control and ascii extremes
    send_beat(8'($urandom), 1'b1, 1'b1, 1'b1);
    send_beat(CH_QUOTE,  1'b1, 1'b0, 1'b0);
    send_beat(CH_BSLASH, 1'b0, 1'b0, 1'b0);
    send_beat(CH_LF,     1'b0, 1'b0, 1'b0);
    send_beat(CH_CR,     1'b0, 1'b0, 1'b0);
    send_beat(CH_TAB,    1'b0, 1'b0, 1'b0);
    send_beat(CH_BS,     1'b0, 1'b0, 1'b0);
    send_beat(CH_FF,     1'b0, 1'b0, 1'b0);
    send_beat(8'h00,     1'b0, 1'b0, 1'b0);
    send_beat(8'h7F,     1'b0, 1'b0, 1'b0);
    // overlong pair, then the stray continuation left behind
    send_beat(8'hC0, 1'b0, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0, 1'b0);
    // four-byte form above the largest code point
    send_beat(8'hF4, 1'b0, 1'b0, 1'b0);
    send_beat(8'h90, 1'b0, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0, 1'b0);
    // valid four-byte sequence held until complete
    send_beat(8'hF0, 1'b0, 1'b0, 1'b0);
    send_beat(8'h9F, 1'b0, 1'b0, 1'b0);
    send_beat(8'h98, 1'b0, 1'b0, 1'b0);
    send_beat(8'h80, 1'b0, 1'b0, 1'b0);
    // truncated sequence flushed by the closing beat
    send_beat(8'hE2, 1'b0, 1'b0, 1'b0);
    send_beat(8'h82, 1'b0, 1'b1, 1'b0);
    // new string while a lead is held, then an invalid lead byte at the close
    send_beat(8'hC3, 1'b1, 1'b0, 1'b0);
    send_beat(8'h41, 1'b1, 1'b0, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b1, 1'b0);
    // byte outside any string, then a beat with neither byte nor flags
    send_beat(CH_QUOTE, 1'b0, 1'b0, 1'b0);
    send_beat(8'($urandom), 1'b0, 1'b0, 1'b1);

    // random phases: slow receiver, then slow sender, then full rate
    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 12;
          rx_idle_pct = 70;
        end
        1: begin
          tx_idle_pct = 70;
          rx_idle_pct = 12;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_target = beats_sent + PHASE_BEATS;
      while (beats_sent < phase_target) begin
        if ($urandom_range(0, 9) == 0) begin
          // noise: beats with every field random
          repeat ($urandom_range(1, 3))
            send_beat(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)));
        end else begin
          send_string();
        end
      end
      drain();
    end

    $display("%0d input beats in %0d random strings plus directed escapes and utf-8 cases,",
             beats_sent, strings_sent);
    $display("%0d output bytes compared across three idle profiles", sb.checked);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("json_string_escaper_utf8_core verification clean");
    end else begin
      $display("json_string_escaper_utf8_core verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/jse_pkg.sv
rtl/jse_front.sv
rtl/jse_queue.sv
rtl/jse_back.sv
rtl/json_string_escaper_utf8_core.sv
dv/escape_scoreboard_pkg.sv
dv/testbench.sv
